@@ hdl/per_source_log_rate_limiter_assert.svh @@
// ----------------------------------------------------------------------------
// per_source_log_rate_limiter_assert.svh
// assertion macros used by the checker file of the rate limiter
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_LOG_RATE_LIMITER_ASSERT_SVH
`define PER_SOURCE_LOG_RATE_LIMITER_ASSERT_SVH

// same-cycle implication, ignored while reset is held
`define PSRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while reset is held
`define PSRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after a reset cycle
`define PSRL_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/psrl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_pkg
// types, constants and helpers of the per-source log rate limiter
// ----------------------------------------------------------------------------
package psrl_pkg;

  localparam int MAX_GROUPS    = 2047;
  localparam int SLOT_W        = 11;
  localparam int TOTAL_W       = 12;
  localparam int NUM_POOLS     = 5;
  localparam int POOL_W        = 3;
  localparam int KEY_W         = 64;
  localparam int TS_W          = 48;
  localparam int WIN_W         = 32;
  localparam int BL_W          = 16;
  localparam int CNT_W         = 32;
  localparam int FREE_W        = 64;
  localparam int LOG2_W        = 6;
  localparam int CHUNK_W       = 16;
  localparam int NUM_CHUNKS    = 4;
  localparam int POS_W         = 4;
  localparam int LOG2_NO_SCALE = 20;
  localparam int SCALE_OFFSET  = 16;
  localparam int SCALE_SHIFT   = 2;
  localparam int BURST_W       = 20;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_WINDOW_US   = 8'd0;
  localparam cfg_idx_t REG_BURST_LIMIT = 8'd1;

  localparam logic [WIN_W-1:0] WINDOW_US_RST   = 32'd30000000;
  localparam logic [BL_W-1:0]  BURST_LIMIT_RST = 16'd10000;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [KEY_W-1:0]  source_key;
    logic [2:0]        priority_req;
    logic [TS_W-1:0]   timestamp_us;
    logic [FREE_W-1:0] free_bytes;
  } in_t;

  typedef struct packed {
    logic             permitted;
    logic [CNT_W-1:0] dropped_before;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TS_W-1:0]    ts;
    logic [POOL_W-1:0]  pool;
    logic [BURST_W-1:0] burst;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic [TS_W-1:0]  start;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] supp;
  } pool_t;

  typedef pool_t [NUM_POOLS-1:0] row_t;

  // syslog priority to pool
  function automatic logic [POOL_W-1:0] pool_of_priority(input logic [2:0] prio);
    logic [POOL_W-1:0] p;
    unique case (prio) inside
      3'd0, 3'd1, 3'd2: p = 3'd0;
      3'd3:             p = 3'd1;
      3'd4:             p = 3'd2;
      3'd5, 3'd6:       p = 3'd3;
      default:          p = 3'd4;
    endcase
    return p;
  endfunction

  // ring slot increment with wrap
  function automatic slot_t slot_inc(input slot_t s);
    return (s == slot_t'(MAX_GROUPS - 1)) ? '0 : s + slot_t'(1);
  endfunction

endpackage

@@ hdl/per_source_log_rate_limiter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_log_rate_limiter
// per-source fixed-window burst limiter for log messages
// ----------------------------------------------------------------------------
// Requests enter on in_push/in_full, one per message, and each gives exactly
// one result on out_data while out_empty is low; out_pop takes it.
// Registers are written on cfg_valid/cfg_ready: index 0 window_us, index 1
// burst_limit; write them only while no request is in flight.
// The front classifies a request in stage registers s0 and s1 and hands it
// over a two-entry queue. The back starts from idle and scans the group table
// from the head one entry at a time, a read and then a compare per entry; a hit
// goes to the pool update. A miss evicts the head while the table is at the cap,
// pops expired groups from the head, checking each pool by pool, checks the head
// that stays and inserts the new group. The pool update then reads the row and
// evaluates the pool. The back takes a new request only once it is idle again,
// so throughput is set by that scan.
// The front keeps accepting while results wait; a stalled receiver backs up
// the two-entry result queue, then the back, then in_full.
// Reset empties the table, queues and pipelines at once; no clearing pass.
// ----------------------------------------------------------------------------
module per_source_log_rate_limiter import psrl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_t                   in_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WIN_W-1:0] window_us_r;
  logic [BL_W-1:0]  burst_limit_r;
  logic             fq_push;
  logic             fq_full;
  item_t            fq_wdata;
  logic             fq_pop;
  logic             fq_empty;
  item_t            fq_rdata;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_us_r   <= WINDOW_US_RST;
      burst_limit_r <= BURST_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_US:   window_us_r   <= cfg_data;
        REG_BURST_LIMIT: burst_limit_r <= cfg_data[BL_W-1:0];
        default: ;
      endcase
    end
  end

  psrl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .burst_limit (burst_limit_r),
    .q_push      (fq_push),
    .q_full      (fq_full),
    .q_data      (fq_wdata)
  );

  psrl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .full    (fq_full),
    .wr_data (fq_wdata),
    .pop     (fq_pop),
    .empty   (fq_empty),
    .rd_data (fq_rdata)
  );

  psrl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (fq_empty),
    .q_pop       (fq_pop),
    .q_data      (fq_rdata),
    .window_us   (window_us_r),
    .burst_limit (burst_limit_r),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .out_data    (out_data)
  );

endmodule

@@ hdl/psrl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_front
// accepts requests, maps the priority to a pool and scales the burst
// ----------------------------------------------------------------------------
module psrl_front import psrl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  in_t             in_data,
  input  logic [BL_W-1:0] burst_limit,
  output logic            q_push,
  input  logic            q_full,
  output item_t           q_data
);

  logic                  s0_v_r;
  logic [KEY_W-1:0]      s0_key_r;
  logic [TS_W-1:0]       s0_ts_r;
  logic [POOL_W-1:0]     s0_pool_r;
  logic [NUM_CHUNKS-1:0] s0_nz_r;
  logic [POS_W-1:0]      s0_pos_r [NUM_CHUNKS];
  logic                  s1_v_r;
  item_t                 s1_item_r;

  logic                  chunk_nz [NUM_CHUNKS];
  logic [POS_W-1:0]      chunk_pos [NUM_CHUNKS];
  logic [LOG2_W-1:0]     k;
  logic [LOG2_W-1:0]     k_off;
  logic [BL_W+LOG2_W-1:0] prod;
  logic [BURST_W-1:0]    burst_nxt;
  logic                  s0_go;
  logic                  s1_go;
  logic                  accept;

  // handshake between the two stages
  assign s1_go  = s1_v_r && !q_full;
  assign s0_go  = s0_v_r && (!s1_v_r || s1_go);
  assign in_full = s0_v_r && !s0_go;
  assign accept = in_push && !in_full;
  assign q_push = s1_go;
  assign q_data = s1_item_r;

  // leading one inside each 16-bit chunk of the free space
  always_comb begin
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      chunk_nz[c]  = |in_data.free_bytes[c*CHUNK_W +: CHUNK_W];
      chunk_pos[c] = '0;
      for (int b = 0; b < CHUNK_W; b++) begin
        if (in_data.free_bytes[c*CHUNK_W + b]) chunk_pos[c] = POS_W'(b);
      end
    end
  end

  // floor log2 from the highest nonzero chunk, then burst scaling
  always_comb begin
    k = '0;
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      if (s0_nz_r[c]) k = {2'(c), s0_pos_r[c]};
    end
    k_off = k - LOG2_W'(SCALE_OFFSET);
    prod  = {{LOG2_W{1'b0}}, burst_limit} * {{BL_W{1'b0}}, k_off};
    if (k <= LOG2_W'(LOG2_NO_SCALE)) begin
      burst_nxt = {{(BURST_W-BL_W){1'b0}}, burst_limit};
    end else begin
      burst_nxt = prod[BURST_W+SCALE_SHIFT-1:SCALE_SHIFT];
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      if (accept) s0_v_r <= 1'b1;
      else if (s0_go) s0_v_r <= 1'b0;
      if (s0_go) s1_v_r <= 1'b1;
      else if (s1_go) s1_v_r <= 1'b0;
    end
    if (accept) begin
      s0_key_r  <= in_data.source_key;
      s0_ts_r   <= in_data.timestamp_us;
      s0_pool_r <= pool_of_priority(in_data.priority_req);
      for (int c = 0; c < NUM_CHUNKS; c++) begin
        s0_nz_r[c]  <= chunk_nz[c];
        s0_pos_r[c] <= chunk_pos[c];
      end
    end
    if (s0_go) begin
      s1_item_r.key   <= s0_key_r;
      s1_item_r.ts    <= s0_ts_r;
      s1_item_r.pool  <= s0_pool_r;
      s1_item_r.burst <= burst_nxt;
    end
  end

endmodule

@@ hdl/psrl_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_queue
// two-entry queue of classified requests between front and back
// ----------------------------------------------------------------------------
module psrl_queue import psrl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  full,
  input  item_t wr_data,
  input  logic  pop,
  output logic  empty,
  output item_t rd_data
);

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

@@ hdl/psrl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_back
// group lookup, eviction, insertion and fixed-window pool update
// ----------------------------------------------------------------------------
module psrl_back import psrl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  output logic             q_pop,
  input  item_t            q_data,
  input  logic [WIN_W-1:0] window_us,
  input  logic [BL_W-1:0]  burst_limit,
  input  logic             out_pop,
  output logic             out_empty,
  output out_t             out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_EVICT, S_EXP_RD, S_EXP_CHK,
    S_INSERT, S_POOL_RD, S_POOL_EVAL
  } state_t;

  state_t             state_r;
  slot_t              head_r;
  logic [TOTAL_W-1:0] total_r;
  slot_t              ptr_r;
  logic [TOTAL_W-1:0] idx_r;
  slot_t              slot_r;
  logic [POOL_W-1:0]  pidx_r;
  item_t              item_r;

  // group tables
  logic [KEY_W-1:0] key_mem  [MAX_GROUPS];
  logic [WIN_W-1:0] intv_mem [MAX_GROUPS];
  row_t             row_mem  [MAX_GROUPS];
  logic [KEY_W-1:0] key_q;
  logic [WIN_W-1:0] intv_q;
  row_t             row_q;

  // result queue
  out_t       oq_r [2];
  logic       oq_wr_r;
  logic       oq_rd_r;
  logic [1:0] oq_cnt_r;

  logic               start;
  logic [TOTAL_W-1:0] ins_sum;
  slot_t              ins_slot;
  logic               key_hit;
  logic               intv_we;
  slot_t              intv_waddr;
  logic               row_re;
  slot_t              row_raddr;
  logic               row_we;
  slot_t              row_waddr;
  row_t               row_wdata;
  logic               disabled;
  pool_t              pv;
  pool_t              pv_new;
  out_t               res;
  logic [TS_W:0]      exp_end;
  logic [TS_W:0]      win_end;
  logic               oq_push;
  logic               oq_pop;

  assign start   = (state_r == S_IDLE) && !q_empty && (oq_cnt_r != 2'd2);
  assign q_pop   = start;
  assign key_hit = (key_q == item_r.key);

  // slot after the last live group
  assign ins_sum  = {1'b0, head_r} + total_r;
  assign ins_slot = (ins_sum >= TOTAL_W'(MAX_GROUPS)) ?
                    SLOT_W'(ins_sum - TOTAL_W'(MAX_GROUPS)) : SLOT_W'(ins_sum);

  // memory port control
  always_comb begin
    intv_we    = (state_r == S_INSERT) || ((state_r == S_SCAN_CMP) && key_hit);
    intv_waddr = (state_r == S_INSERT) ? ins_slot : ptr_r;
    row_re     = (state_r == S_EXP_RD) || (state_r == S_POOL_RD);
    row_raddr  = (state_r == S_EXP_RD) ? head_r : slot_r;
    row_we     = (state_r == S_INSERT) || ((state_r == S_POOL_EVAL) && !disabled);
    row_waddr  = (state_r == S_INSERT) ? ins_slot : slot_r;
  end

  // expiry test of one pool of the head group
  assign exp_end = {1'b0, row_q[pidx_r].start} + {{(TS_W+1-WIN_W){1'b0}}, intv_q};

  // pool update
  always_comb begin
    disabled = (window_us == '0) || (burst_limit == '0);
    pv       = row_q[item_r.pool];
    win_end  = {1'b0, pv.start} + {{(TS_W+1-WIN_W){1'b0}}, window_us};
    pv_new   = pv;
    res.permitted      = 1'b1;
    res.dropped_before = '0;
    if (!disabled) begin
      if (!pv.valid) begin
        pv_new.valid = 1'b1;
        pv_new.start = item_r.ts;
        pv_new.count = CNT_W'(1);
        pv_new.supp  = '0;
      end else if (win_end < {1'b0, item_r.ts}) begin
        res.dropped_before = pv.supp;
        pv_new.start = item_r.ts;
        pv_new.count = CNT_W'(1);
        pv_new.supp  = '0;
      end else if (pv.count < {{(CNT_W-BURST_W){1'b0}}, item_r.burst}) begin
        pv_new.count = pv.count + CNT_W'(1);
      end else begin
        res.permitted = 1'b0;
        if (pv.supp != '1) pv_new.supp = pv.supp + CNT_W'(1);
      end
    end
    row_wdata = '0;
    if (state_r == S_POOL_EVAL) begin
      row_wdata = row_q;
      row_wdata[item_r.pool] = pv_new;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (state_r == S_INSERT) key_mem[ins_slot] <= item_r.key;
    key_q <= key_mem[ptr_r];
    if (intv_we) intv_mem[intv_waddr] <= window_us;
    if (state_r == S_EXP_RD) intv_q <= intv_mem[head_r];
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (row_re) row_q <= row_mem[row_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      total_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r  <= q_data;
            ptr_r   <= head_r;
            idx_r   <= '0;
            state_r <= (total_r == '0) ? S_EVICT : S_SCAN_RD;
          end
        end
        S_SCAN_RD: state_r <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (key_hit) begin
            slot_r  <= ptr_r;
            state_r <= S_POOL_RD;
          end else if (idx_r + TOTAL_W'(1) == total_r) begin
            state_r <= S_EVICT;
          end else begin
            idx_r   <= idx_r + TOTAL_W'(1);
            ptr_r   <= slot_inc(ptr_r);
            state_r <= S_SCAN_RD;
          end
        end
        S_EVICT: begin
          if (total_r >= TOTAL_W'(MAX_GROUPS)) begin
            head_r  <= slot_inc(head_r);
            total_r <= total_r - TOTAL_W'(1);
          end else begin
            state_r <= S_EXP_RD;
          end
        end
        S_EXP_RD: begin
          pidx_r  <= '0;
          state_r <= (total_r == '0) ? S_INSERT : S_EXP_CHK;
        end
        S_EXP_CHK: begin
          if (exp_end >= {1'b0, item_r.ts}) begin
            state_r <= S_INSERT;
          end else if (pidx_r == POOL_W'(NUM_POOLS - 1)) begin
            head_r  <= slot_inc(head_r);
            total_r <= total_r - TOTAL_W'(1);
            state_r <= S_EXP_RD;
          end else begin
            pidx_r <= pidx_r + POOL_W'(1);
          end
        end
        S_INSERT: begin
          slot_r  <= ins_slot;
          total_r <= total_r + TOTAL_W'(1);
          state_r <= S_POOL_RD;
        end
        S_POOL_RD:   state_r <= S_POOL_EVAL;
        S_POOL_EVAL: state_r <= S_IDLE;
        default:     state_r <= S_IDLE;
      endcase
    end
  end

  // result queue, room is reserved when a request starts
  assign oq_push   = (state_r == S_POOL_EVAL);
  assign oq_pop    = out_pop && !out_empty;
  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_data  = oq_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (oq_push) oq_wr_r <= ~oq_wr_r;
      if (oq_pop) oq_rd_r <= ~oq_rd_r;
      if (oq_push && !oq_pop) oq_cnt_r <= oq_cnt_r + 2'd1;
      else if (oq_pop && !oq_push) oq_cnt_r <= oq_cnt_r - 2'd1;
    end
    if (oq_push) oq_r[oq_wr_r] <= res;
  end

endmodule

@@ hdl/psrl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_checker
// port-level checks of the rate limiter, bound to the top level
// ----------------------------------------------------------------------------
`include "per_source_log_rate_limiter_assert.svh"

module psrl_checker import psrl_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_empty,
  input logic out_pop,
  input out_t out_data
);

  logic drop_rpt;

  assign drop_rpt = !out_empty && (out_data.dropped_before != '0);

  // no result survives reset
  `PSRL_ASSERT_RESET(a_empty_after_reset, out_empty, "result pending after reset")

  // a waiting result stays until taken
  `PSRL_ASSERT_NEXT(a_out_holds, !out_empty && !out_pop, !out_empty, "result lost")

  // a waiting result does not change until taken
  `PSRL_ASSERT_NEXT(a_out_stable, !out_empty && !out_pop, $stable(out_data), "result changed")

  // a suppressed count is only reported on a permitted message
  `PSRL_ASSERT_NOW(a_drop_permitted, drop_rpt, out_data.permitted, "drop count on suppressed")

endmodule

bind per_source_log_rate_limiter psrl_checker u_psrl_checker (.*);

@@ bench/psrl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrl_scoreboard
// scoreboard for the per-source log rate limiter
// ----------------------------------------------------------------------------
// Watches the request, result and register channels. Every accepted request
// runs through a behavioral copy of the group table and pools. The result it
// gives is queued and compared field by field with each popped result.
// ----------------------------------------------------------------------------
module psrl_scoreboard import psrl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  in_t                   in_data,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  out_t                  out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_due
);

  // mirrored registers
  logic [WIN_W-1:0] win_len = WINDOW_US_RST;
  logic [BL_W-1:0]  burst_base = BURST_LIMIT_RST;

  // mirrored group table
  logic [KEY_W-1:0] grp_key [MAX_GROUPS];
  logic [WIN_W-1:0] grp_ivl [MAX_GROUPS];
  logic [TS_W-1:0]  pl_start [MAX_GROUPS][NUM_POOLS];
  logic [CNT_W-1:0] pl_count [MAX_GROUPS][NUM_POOLS];
  logic [CNT_W-1:0] pl_supp [MAX_GROUPS][NUM_POOLS];
  logic             pl_used [MAX_GROUPS][NUM_POOLS];
  int               head_slot = 0;
  int               live_groups = 0;

  out_t verdicts_due[$];

  assign results_due = verdicts_due.size();

  function automatic int ring_pos(int pos);
    int s;
    s = head_slot + pos;
    if (s >= MAX_GROUPS) s -= MAX_GROUPS;
    return s;
  endfunction

  function automatic bit stale_group(int s, logic [TS_W-1:0] ts);
    for (int p = 0; p < NUM_POOLS; p++)
      if (64'(pl_start[s][p]) + 64'(grp_ivl[s]) >= 64'(ts)) return 0;
    return 1;
  endfunction

  // burst after scaling by floor(log2(free space))
  function automatic longint unsigned burst_for(logic [FREE_W-1:0] avail);
    int k;
    k = 0;
    for (int b = 0; b < FREE_W; b++)
      if (avail[b]) k = b;
    if (k <= LOG2_NO_SCALE) return longint'(burst_base);
    return (64'(burst_base) * 64'(k - SCALE_OFFSET)) / 4;
  endfunction

  task automatic limit_message(input in_t r, output out_t o);
    int s;
    int p;
    bit hit;
    longint unsigned burst;
    hit = 0;
    s = 0;
    o.permitted = 1'b1;
    o.dropped_before = '0;
    // group lookup, oldest first
    for (int i = 0; i < live_groups && !hit; i++) begin
      if (grp_key[ring_pos(i)] == r.source_key) begin
        s = ring_pos(i);
        hit = 1;
      end
    end
    // miss: evict to the cap, drop stale heads, append a fresh group
    if (!hit) begin
      while (live_groups >= MAX_GROUPS) begin
        head_slot = ring_pos(1);
        live_groups--;
      end
      while (live_groups > 0 && stale_group(head_slot, r.timestamp_us)) begin
        head_slot = ring_pos(1);
        live_groups--;
      end
      s = ring_pos(live_groups);
      live_groups++;
      grp_key[s] = r.source_key;
      for (int q = 0; q < NUM_POOLS; q++) begin
        pl_start[s][q] = '0;
        pl_count[s][q] = '0;
        pl_supp[s][q] = '0;
        pl_used[s][q] = 1'b0;
      end
    end
    grp_ivl[s] = win_len;
    if (win_len == 0 || burst_base == 0) return;
    burst = burst_for(r.free_bytes);
    case (r.priority_req)
      3'd0, 3'd1, 3'd2: p = 0;
      3'd3:             p = 1;
      3'd4:             p = 2;
      3'd5, 3'd6:       p = 3;
      default:          p = 4;
    endcase
    // first message to the pool opens a window
    if (!pl_used[s][p]) begin
      pl_used[s][p] = 1'b1;
      pl_supp[s][p] = '0;
      pl_count[s][p] = 1;
      pl_start[s][p] = r.timestamp_us;
    end else if (64'(pl_start[s][p]) + 64'(win_len) < 64'(r.timestamp_us)) begin
      // window reopened, report what was suppressed
      o.dropped_before = pl_supp[s][p];
      pl_supp[s][p] = '0;
      pl_count[s][p] = 1;
      pl_start[s][p] = r.timestamp_us;
    end else if (64'(pl_count[s][p]) < burst) begin
      pl_count[s][p]++;
    end else begin
      if (pl_supp[s][p] != '1) pl_supp[s][p]++;
      o.permitted = 1'b0;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    out_t exp_res;
    if (rst_n) begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW_US) win_len <= cfg_data[WIN_W-1:0];
        else if (cfg_index == REG_BURST_LIMIT) burst_base <= cfg_data[BL_W-1:0];
      end
      // accepted request
      if (in_push && !in_full) begin
        limit_message(in_data, exp_res);
        verdicts_due.push_back(exp_res);
      end
      // popped result
      if (out_pop && !out_empty) begin
        if (verdicts_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_data);
          fail_count++;
        end else begin
          exp_res = verdicts_due.pop_front();
          if (exp_res.permitted !== out_data.permitted ||
              exp_res.dropped_before !== out_data.dropped_before) begin
            if (fail_count < 10)
              $display("mismatch: expected permitted=%0d dropped=%0d, got %0d %0d",
                       exp_res.permitted, exp_res.dropped_before,
                       out_data.permitted, out_data.dropped_before);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// top of the per-source log rate limiter bench
// ----------------------------------------------------------------------------
// Directed requests at the field extremes, then random traffic over a small
// set of recurring sources, under several register settings. Timestamps walk
// mostly forward, with rare small steps back, at a pace tied to the window so windows reopen and groups expire.
// ----------------------------------------------------------------------------
module tb;
  import psrl_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  in_t                   in_data = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = REG_WINDOW_US;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    results_due;

  int                    send_idle = 30;
  int                    recv_idle = 78;
  bit                    hold_req = 0;
  logic [TS_W-1:0]       now_us = '0;
  logic [KEY_W-1:0]      sources [24];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  per_source_log_rate_limiter DUT (.*);

  psrl_scoreboard u_checker (.*);

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random pops, plus long hold-offs on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_request(input in_t r);
    bit full_seen;
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= r;
    forever begin
      @(negedge clk);
      full_seen = in_full;
      @(posedge clk);
      if (!full_seen) break;
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
      if (rdy) break;
    end
    cfg_valid <= 1'b0;
  endtask

  // wait for every result, then reprogram both registers
  task automatic reconfigure(input logic [WIN_W-1:0] win, input logic [BL_W-1:0] bl);
    in_push <= 1'b0;
    wait (results_due == 0);
    repeat (20) @(posedge clk);
    write_reg(REG_WINDOW_US, CFG_DATA_W'(win));
    write_reg(REG_BURST_LIMIT, CFG_DATA_W'(bl));
  endtask

  function automatic logic [FREE_W-1:0] rand_space();
    logic [FREE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return v >> $urandom_range(63);
      1: return v >> $urandom_range(44, 63);
      default: return v >> $urandom_range(30, 50);
    endcase
  endfunction

  task automatic random_traffic(input int n, input longint unsigned step_max);
    in_t r;
    for (int i = 0; i < n; i++) begin
      r.source_key = ($urandom_range(99) < 6) ? {$urandom, $urandom}
                                              : sources[$urandom_range(23)];
      r.priority_req = 3'($urandom_range(7));
      if ($urandom_range(99) < 3) now_us = now_us - TS_W'($urandom_range(50));
      else now_us = now_us + TS_W'(($urandom * 64'd65536 + $urandom) % (step_max + 1));
      r.timestamp_us = now_us;
      r.free_bytes = rand_space();
      if (i == n / 2 && n > 200) hold_req = 1;
      send_request(r);
    end
  endtask

  initial begin
    in_t r;
    for (int i = 0; i < 24; i++) sources[i] = {$urandom, $urandom};
    sources[0] = '0;
    sources[1] = '1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: priorities, key and time extremes, space around the scaling knee
    for (int p = 0; p < 8; p++) begin
      r.source_key = (p < 4) ? '0 : '1;
      r.priority_req = 3'(p);
      r.timestamp_us = '0;
      r.free_bytes = '0;
      send_request(r);
    end
    r = '{source_key: 64'h5a5a_5a5a_a5a5_a5a5, priority_req: 3'd7,
          timestamp_us: '1, free_bytes: '1};
    send_request(r);
    r.free_bytes = 64'd1 << 20;
    send_request(r);
    r.free_bytes = 64'd1 << 21;
    send_request(r);
    r.timestamp_us = 48'd5;
    send_request(r);
    reconfigure(32'd100, 16'd1);
    for (int i = 0; i < 6; i++) begin
      r = '{source_key: 64'd7, priority_req: 3'd3,
            timestamp_us: 48'(i * 60), free_bytes: 64'd1 << (20 + i)};
      send_request(r);
    end

    // random phases, idling swapped after the first third and removed for the last third
    reconfigure(WINDOW_US_RST, BURST_LIMIT_RST);
    now_us = '0;
    random_traffic(320, 2000000);
    reconfigure(32'd100, 16'd3);
    random_traffic(320, 60);
    send_idle = 78;
    recv_idle = 30;
    reconfigure(32'd0, 16'd5);
    random_traffic(320, 40);
    reconfigure(32'd1000, 16'd0);
    random_traffic(320, 300);
    send_idle = 0;
    recv_idle = 0;
    reconfigure('1, '1);
    random_traffic(320, 64'hffff_ffff);
    reconfigure(32'd50, 16'd1);
    random_traffic(320, 30);

    in_push <= 1'b0;
    wait (results_due == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/psrl_pkg.sv
hdl/psrl_front.sv
hdl/psrl_queue.sv
hdl/psrl_back.sv
hdl/per_source_log_rate_limiter.sv
hdl/psrl_checker.sv
bench/psrl_checker.sv
bench/tb.sv
